// File: hdl/mcf_pkg.sv
// Shared types and constants for the modulated delay chorus/flanger.
// Used by the sine table and the top level; depends on nothing else.
package mcf_pkg;

   localparam int TURN_W = 24;
   localparam int SINE_W = 24;

   typedef logic signed [SINE_W-1:0] sine_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_LFO_STEP     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_Q8     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY_Q8     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIX_Q16      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAP_COUNT    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_OFFSET = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FEEDBACK_Q16 = 3'd6;

   localparam logic [16:0]        MIX_ONE = 17'd65536;
   localparam logic signed [16:0] FB_HI   = 17'sd62259;
   localparam logic signed [16:0] FB_LO   = -17'sd62259;

   localparam longint unsigned PI_Q30      = 64'd3373259426;
   localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned SINE_MAX    = 64'd8388607;
   localparam longint unsigned SERIES_DEN [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                  64'd110, 64'd156, 64'd210};

endpackage

// File: hdl/modulated_delay_chorus_flanger_top.sv
// Top level of the modulated delay chorus/flanger: delay line memory,
// tap sequencer, tap averaging and dry/wet mix. Depends on mcf_pkg and
// mcf_sine_rom.
//
// Each request carries one signed sample and yields one response sample.
// A request walks its T taps in turn, T being the tap count (1 to 3 by
// default); every tap goes through the sine table, one multiply, a position
// step and two reads of the single read port of the delay line; when mix
// and feedback are both zero the taps are skipped. A finished response
// waits in an output register while the next request is taken. The delay
// line needs no clearing pass: entries not yet written since reset read as
// zero.
module modulated_delay_chorus_flanger_top import mcf_pkg::*; #(
   parameter int LINE_DEPTH       = 2048,
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int MAX_TAPS         = 3,
   parameter int SAMPLE_BITS      = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0] req_tdata,  // sample_in
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,  // sample_out
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int SB     = SAMPLE_BITS;
   localparam int DW     = ((SAMPLE_BITS+7)/8)*8;
   localparam int LB     = $clog2(LINE_DEPTH);
   localparam int XB     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int TVB    = $clog2(MAX_TAPS + 1);
   localparam int BACK_W = (LB + 10 > 20) ? LB + 10 : 20;
   localparam int WS     = SB + 9 + $clog2(MAX_TAPS);
   localparam int VW     = WS - 7;
   localparam int SW     = SB + 3;
   localparam int PB     = SB + 20;

   localparam logic signed [BACK_W-1:0] BACK_LO = BACK_W'(256);
   localparam logic signed [BACK_W-1:0] BACK_HI = BACK_W'((LINE_DEPTH - 2) * 256);
   localparam logic signed [SW-1:0] SAT_HI = SW'((longint'(1) << (SB - 1)) - 1);
   localparam logic signed [SW-1:0] SAT_LO = -SW'(longint'(1) << (SB - 1));

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_TURN  = 4'd1;
   localparam logic [3:0] ST_MUL   = 4'd2;
   localparam logic [3:0] ST_POS   = 4'd3;
   localparam logic [3:0] ST_RDA   = 4'd4;
   localparam logic [3:0] ST_RDB   = 4'd5;
   localparam logic [3:0] ST_ACC   = 4'd6;
   localparam logic [3:0] ST_DVA   = 4'd7;
   localparam logic [3:0] ST_DVB   = 4'd8;
   localparam logic [3:0] ST_DVC   = 4'd9;
   localparam logic [3:0] ST_FBM   = 4'd10;
   localparam logic [3:0] ST_WRITE = 4'd11;

   function automatic logic signed [SW-1:0] round16(input logic signed [PB-1:0] p);
      logic [PB-1:0] mag;
      logic [PB-1:0] r;
      mag = (p < 0) ? PB'(-p) : PB'(p);
      r   = (mag + (PB'(1) << 15)) >> 16;
      return (p < 0) ? -SW'($signed({1'b0, r})) : SW'($signed({1'b0, r}));
   endfunction

   function automatic logic [SB-1:0] sat(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] c;
      c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
      return c[SB-1:0];
   endfunction

   logic [3:0] state_ff, state_in;

   logic [23:0]        lfo_step_ff;
   logic [17:0]        depth_q8_ff;
   logic [17:0]        delay_q8_ff;
   logic [16:0]        mix_q16_ff;
   logic [1:0]         tap_count_ff;
   logic [15:0]        phase_offset_ff;
   logic signed [16:0] feedback_q16_ff;

   logic [LB-1:0] wp_ff;
   logic          wrapped_ff;
   logic [23:0]   lfo_ff;
   logic          rsp_valid_ff;
   logic [SB-1:0] rsp_data_ff;

   logic signed [SB-1:0] x_ff;
   logic [16:0]          mix_use_ff;
   logic signed [16:0]   fb_use_ff;
   logic [XB-1:0]        tsel_ff;
   logic [XB-1:0]        t_ff;
   logic signed [42:0]   swing_prod_ff;
   logic signed [BACK_W-1:0] back_ff;
   logic [LB-1:0]        addr_a_ff;
   logic [7:0]           frac_ff;
   logic signed [SB-1:0] a_ff;
   logic signed [WS-1:0] wsum_ff;
   logic [VW-1:0]        v_ff;
   logic                 neg_ff;
   logic [2*VW:0]        qprod_ff;
   logic signed [SB:0]   wet_ff;
   logic signed [SB+17:0] fbp_ff;
   logic signed [SB+19:0] mxp_ff;

   logic [SB-1:0] line_mem [LINE_DEPTH];
   logic [SB-1:0] rd_q_ff;
   logic          rd_ok_ff;

   logic [23:0]   tap_ofs [MAX_TAPS][MAX_TAPS];
   logic [VW:0]   recip [MAX_TAPS];

   logic                     req_fire;
   logic                     out_free;
   logic [23:0]              turn;
   sine_type                 sine_q;
   logic [16:0]              mix_c;
   logic signed [16:0]       fb_c;
   logic [XB-1:0]            tsel_c;
   logic [TVB-1:0]           tval;
   logic [42:0]              smag;
   logic [18:0]              swing_mag;
   logic signed [BACK_W-1:0] swing_s;
   logic signed [BACK_W-1:0] back_raw;
   logic signed [BACK_W-1:0] back_cl;
   logic [LB-1:0]            whole;
   logic [LB-1:0]            addr_a;
   logic [LB-1:0]            addr_b;
   logic [LB-1:0]            rd_addr;
   logic signed [SB-1:0]     rd_sample;
   logic signed [SB:0]       dab;
   logic signed [SB+9:0]     dprod;
   logic signed [WS-1:0]     term;
   logic [WS-1:0]            wmag;
   logic [VW:0]              q0;
   logic [VW:0]              qt;
   logic [VW:0]              rem;
   logic [VW:0]              q;
   logic signed [SB:0]       wet_c;
   logic signed [SB+1:0]     wx;
   logic                     line_we;
   logic [SB-1:0]            wr_data;
   logic [SB-1:0]            y_c;
   logic [LB-1:0]            wp_next;

   for (genvar g = 0; g < MAX_TAPS; g++) begin : g_taps
      for (genvar h = 0; h < MAX_TAPS; h++) begin : g_ofs
         localparam longint unsigned OFS =
            (h <= g) ? ((longint'(h) << 24) / (2 * (g + 1))) : 64'd0;
         assign tap_ofs[g][h] = OFS[23:0];
      end
      localparam longint unsigned RCP = (longint'(1) << VW) / (g + 1);
      assign recip[g] = RCP[VW:0];
   end

   mcf_sine_rom #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
   ) u_sine (
      .clock (clock),
      .turn  (turn),
      .sine  (sine_q)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DW'(rsp_data_ff);
   assign tval       = TVB'(tsel_ff) + TVB'(1);

   always_comb begin
      mix_c = (mix_q16_ff > MIX_ONE) ? MIX_ONE : mix_q16_ff;
      fb_c  = (feedback_q16_ff > FB_HI) ? FB_HI :
              ((feedback_q16_ff < FB_LO) ? FB_LO : feedback_q16_ff);
      if (tap_count_ff == 2'd0) begin
         tsel_c = '0;
      end else if (int'(tap_count_ff) > MAX_TAPS) begin
         tsel_c = XB'(MAX_TAPS - 1);
      end else begin
         tsel_c = XB'(tap_count_ff - 2'd1);
      end
   end

   assign turn = lfo_ff + {phase_offset_ff, 8'b0} + tap_ofs[tsel_ff][t_ff];

   always_comb begin
      smag      = (swing_prod_ff < 0) ? 43'(-swing_prod_ff) : 43'(swing_prod_ff);
      swing_mag = 19'((smag + (43'd1 << 22)) >> 23);
      swing_s   = (swing_prod_ff < 0) ? -BACK_W'($signed({1'b0, swing_mag}))
                                      : BACK_W'($signed({1'b0, swing_mag}));
      back_raw  = BACK_W'($signed({1'b0, delay_q8_ff})) + swing_s;
      back_cl   = (back_raw < BACK_LO) ? BACK_LO :
                  ((back_raw > BACK_HI) ? BACK_HI : back_raw);
   end

   always_comb begin
      whole = back_ff[LB+7:8];
      if (wp_ff >= whole) begin
         addr_a = wp_ff - whole;
      end else begin
         addr_a = LB'({1'b0, wp_ff} + (LB+1)'(LINE_DEPTH) - {1'b0, whole});
      end
      addr_b  = (addr_a_ff == '0) ? LB'(LINE_DEPTH - 1) : addr_a_ff - LB'(1);
      rd_addr = (state_ff == ST_RDB) ? addr_b : addr_a;
      rd_sample = rd_ok_ff ? $signed(rd_q_ff) : '0;
   end

   always_comb begin
      dab   = (SB+1)'(rd_sample) - (SB+1)'(a_ff);
      dprod = dab * $signed({1'b0, frac_ff});
      term  = (WS'(a_ff) <<< 8) + WS'(dprod);
   end

   always_comb begin
      wmag  = (wsum_ff < 0) ? WS'(-wsum_ff) : WS'(wsum_ff);
      q0    = qprod_ff[2*VW:VW];
      qt    = (VW+1)'(q0 * tval);
      rem   = {1'b0, v_ff} - qt;
      q     = (rem >= (VW+1)'(tval)) ? q0 + (VW+1)'(1) : q0;
      wet_c = neg_ff ? -(SB+1)'($signed(q)) : (SB+1)'($signed(q));
      wx    = (SB+2)'(wet_ff) - (SB+2)'(x_ff);
   end

   always_comb begin
      line_we = (state_ff == ST_WRITE) && out_free;
      wr_data = sat(SW'(x_ff) + round16(PB'(fbp_ff)));
      y_c     = sat(SW'(x_ff) + round16(mxp_ff));
      wp_next = (wp_ff == LB'(LINE_DEPTH - 1)) ? '0 : wp_ff + LB'(1);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (mix_c == '0 && fb_c == '0) ? ST_FBM : ST_TURN;
            end
         end
         ST_TURN:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_POS;
         ST_POS:   state_in = ST_RDA;
         ST_RDA:   state_in = ST_RDB;
         ST_RDB:   state_in = ST_ACC;
         ST_ACC:   state_in = (t_ff == tsel_ff) ? ST_DVA : ST_TURN;
         ST_DVA:   state_in = ST_DVB;
         ST_DVB:   state_in = ST_DVC;
         ST_DVC:   state_in = ST_FBM;
         ST_FBM:   state_in = ST_WRITE;
         ST_WRITE: state_in = out_free ? ST_IDLE : ST_WRITE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         lfo_step_ff     <= '0;
         depth_q8_ff     <= '0;
         delay_q8_ff     <= '0;
         mix_q16_ff      <= '0;
         tap_count_ff    <= 2'd2;
         phase_offset_ff <= '0;
         feedback_q16_ff <= '0;
         wp_ff           <= '0;
         wrapped_ff      <= 1'b0;
         lfo_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         t_ff            <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_LFO_STEP:     lfo_step_ff     <= csr_data[23:0];
               CSR_DEPTH_Q8:     depth_q8_ff     <= csr_data[17:0];
               CSR_DELAY_Q8:     delay_q8_ff     <= csr_data[17:0];
               CSR_MIX_Q16:      mix_q16_ff      <= csr_data[16:0];
               CSR_TAP_COUNT:    tap_count_ff    <= csr_data[1:0];
               CSR_PHASE_OFFSET: phase_offset_ff <= csr_data[15:0];
               CSR_FEEDBACK_Q16: feedback_q16_ff <= $signed(csr_data[16:0]);
               default: ;
            endcase
         end
         if (req_fire) begin
            t_ff <= '0;
         end else if (state_ff == ST_ACC && t_ff != tsel_ff) begin
            t_ff <= t_ff + XB'(1);
         end
         if (line_we) begin
            wp_ff  <= wp_next;
            lfo_ff <= lfo_ff + lfo_step_ff;
            if (wp_ff == LB'(LINE_DEPTH - 1)) begin
               wrapped_ff <= 1'b1;
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff       <= $signed(req_tdata[SB-1:0]);
         mix_use_ff <= mix_c;
         fb_use_ff  <= fb_c;
         tsel_ff    <= tsel_c;
         wsum_ff    <= '0;
         wet_ff     <= '0;
      end
      swing_prod_ff <= $signed({1'b0, depth_q8_ff}) * sine_q;
      if (state_ff == ST_POS) begin
         back_ff <= back_cl;
      end
      if (state_ff == ST_RDA) begin
         addr_a_ff <= addr_a;
         frac_ff   <= back_ff[7:0];
      end
      if (state_ff == ST_RDB) begin
         a_ff <= rd_sample;
      end
      if (state_ff == ST_ACC) begin
         wsum_ff <= wsum_ff + term;
      end
      if (state_ff == ST_DVA) begin
         v_ff   <= VW'(({1'b0, wmag} + ((WS+1)'(tval) << 7)) >> 8);
         neg_ff <= (wsum_ff < 0);
      end
      qprod_ff <= v_ff * recip[tsel_ff];
      if (state_ff == ST_DVC) begin
         wet_ff <= wet_c;
      end
      fbp_ff <= fb_use_ff * wet_ff;
      mxp_ff <= wx * $signed({1'b0, mix_use_ff});
      if (line_we) begin
         rsp_data_ff <= y_c;
      end
   end

   always_ff @(posedge clock) begin
      rd_q_ff  <= line_mem[rd_addr];
      rd_ok_ff <= wrapped_ff || (rd_addr < wp_ff);
   end

   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[wp_ff] <= wr_data;
      end
   end

   a_rsp_after_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && out_free) |=> rsp_valid_ff)
      else $error("response not raised after line write");

   a_wp_only_on_write: assert property (@(posedge clock) disable iff (reset)
      !line_we |=> $stable(wp_ff) && $stable(lfo_ff))
      else $error("write pointer or phase moved without a line write");

   a_tap_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (t_ff <= tsel_ff))
      else $error("tap counter beyond tap count");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_WRITE) |=> !line_we || $past(state_ff) == ST_FBM)
      else $error("line written outside the write step");

endmodule

// File: hdl/mcf_sine_rom.sv
// Sine lookup table with a registered read, built at elaboration from a
// fixed-point Taylor series. Depends on mcf_pkg.
module mcf_sine_rom import mcf_pkg::*; #(
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic              clock,
   input  logic [TURN_W-1:0] turn,
   output sine_type          sine
);

   localparam int IW = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
   localparam int PW = TURN_W + IW + 1;

   function automatic sine_type sine_entry(input longint unsigned k);
      longint unsigned a;
      longint unsigned term;
      longint unsigned sum;
      logic            neg;
      int              n;
      a   = (TWO_PI_Q30 * k) / SINE_TABLE_DEPTH;
      neg = 1'b0;
      if (a >= PI_Q30) begin
         neg = 1'b1;
         a   = a - PI_Q30;
      end
      if (a > HALF_PI_Q30) begin
         a = PI_Q30 - a;
      end
      term = a;
      sum  = a;
      for (n = 1; n <= 7; n++) begin
         term = (term * a) >> 30;
         term = ((term * a) >> 30) / SERIES_DEN[n-1];
         if (n[0]) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      sum = (sum + 64) >> 7;
      if (sum > SINE_MAX) begin
         sum = SINE_MAX;
      end
      return neg ? -sine_type'(sum[SINE_W-1:0]) : sine_type'(sum[SINE_W-1:0]);
   endfunction

   sine_type        rom [SINE_TABLE_DEPTH];
   logic [PW-1:0]   scaled;
   logic [IW-1:0]   idx;
   sine_type        sine_ff;

   for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
      localparam sine_type ENTRY = sine_entry(longint'(k));
      assign rom[k] = ENTRY;
   end

   assign scaled = PW'(turn) * PW'(SINE_TABLE_DEPTH);
   assign idx    = scaled[TURN_W +: IW];

   always_ff @(posedge clock) begin
      sine_ff <= rom[idx];
   end

   assign sine = sine_ff;

endmodule
